>>> hdl/kslp_pkg.sv
// ----------------------------------------------------------------------------
// kslp_pkg
// Shared types and constants of the short/long key press detector.
// ----------------------------------------------------------------------------
package kslp_pkg;

   localparam int PIN_BITS        = 5;
   localparam int KEY_INDEX_WIDTH = 3;
   localparam int DEBOUNCE_WIDTH  = 8;
   localparam int HOLD_WIDTH      = 16;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [1:0] {
      CMD_TICK       = 2'd0,
      CMD_READ_SHORT = 2'd1,
      CMD_READ_LONG  = 2'd2
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_DEBOUNCE_TICKS = 1'd0,
      CSR_HOLD_TICKS     = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic tick;
      logic pressed;
      logic clr_short;
      logic clr_long;
   } key_ctrl_type;

   typedef struct packed {
      logic short_seen;
      logic long_seen;
   } key_flags_type;

endpackage

>>> hdl/kslp_key.sv
// ----------------------------------------------------------------------------
// kslp_key
// One key: debounce, hold and release tracking with sticky press flags.
// ----------------------------------------------------------------------------
module kslp_key (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kslp_pkg::key_ctrl_type               ctrl,
   input  logic [kslp_pkg::DEBOUNCE_WIDTH-1:0]  debounce_ticks,
   input  logic [kslp_pkg::HOLD_WIDTH-1:0]      hold_ticks,
   output kslp_pkg::key_flags_type              flags
);
   import kslp_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_DEBOUNCE = 2'd1,
      MODE_HOLD     = 2'd2,
      MODE_WAIT     = 2'd3
   } mode_type;

   mode_type              mode_ff;
   logic [HOLD_WIDTH-1:0] count_ff;
   logic                  short_ff;
   logic                  long_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
         short_ff <= 1'b0;
         long_ff  <= 1'b0;
      end else begin
         if (ctrl.tick) begin
            unique case (mode_ff)
               MODE_IDLE: begin
                  if (ctrl.pressed) begin
                     count_ff <= HOLD_WIDTH'(debounce_ticks);
                     mode_ff  <= MODE_DEBOUNCE;
                  end
               end
               MODE_DEBOUNCE: begin
                  if (count_ff != '0) begin
                     count_ff <= count_ff - 1'b1;
                  end else if (ctrl.pressed) begin
                     count_ff <= hold_ticks;
                     mode_ff  <= MODE_HOLD;
                  end else begin
                     mode_ff <= MODE_IDLE;
                  end
               end
               MODE_HOLD: begin
                  if (!ctrl.pressed) begin
                     mode_ff <= MODE_WAIT;
                  end else if (count_ff != '0) begin
                     count_ff <= count_ff - 1'b1;
                  end else begin
                     // held through the countdown: flag and re-arm
                     long_ff <= 1'b1;
                     mode_ff <= MODE_IDLE;
                  end
               end
               MODE_WAIT: begin
                  if (!ctrl.pressed) begin
                     short_ff <= 1'b1;
                     mode_ff  <= MODE_IDLE;
                  end
               end
               default: begin
                  mode_ff <= MODE_IDLE;
               end
            endcase
         end
         if (ctrl.clr_short) begin
            short_ff <= 1'b0;
         end
         if (ctrl.clr_long) begin
            long_ff <= 1'b0;
         end
      end
   end

   assign flags.short_seen = short_ff;
   assign flags.long_seen  = long_ff;

endmodule

>>> hdl/key_short_long_press_detector.sv
// ----------------------------------------------------------------------------
// key_short_long_press_detector
// Debounces active-low keys and reports sticky short and long press flags.
// ----------------------------------------------------------------------------
// Path: a request waits in the input register, then its response is loaded into the response register.
// Throughput: one request per cycle while rsp_ready keeps the response slot free; the per-key step is a single update.
// Reset: synchronous; all keys idle, flags and counters cleared,
// debounce_ticks = 0 and hold_ticks = 3.
module key_short_long_press_detector #(
   parameter int KEY_COUNT = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  kslp_pkg::cmd_type                     req_cmd,
   input  logic [kslp_pkg::PIN_BITS-1:0]         req_pin_levels,
   input  logic [kslp_pkg::KEY_INDEX_WIDTH-1:0]  req_key_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_flag_value,
   output logic [kslp_pkg::PIN_BITS-1:0]         rsp_pending_short,
   output logic [kslp_pkg::PIN_BITS-1:0]         rsp_pending_long,
   input  logic                                  csr_wr_en,
   input  kslp_pkg::csr_index_type               csr_index,
   input  logic [kslp_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import kslp_pkg::*;

   logic [DEBOUNCE_WIDTH-1:0]  debounce_ticks_ff;
   logic [HOLD_WIDTH-1:0]      hold_ticks_ff;

   logic                       in_valid_ff;
   cmd_type                    in_cmd_ff;
   logic [PIN_BITS-1:0]        in_pins_ff;
   logic [KEY_INDEX_WIDTH-1:0] in_index_ff;

   logic                       rsp_valid_ff;
   logic                       flag_ff;
   logic                       flag_in;

   logic                       out_free;
   logic                       in_advance;
   logic                       req_fire;

   key_ctrl_type               key_ctrl  [KEY_COUNT];
   key_flags_type              key_flags [KEY_COUNT];

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign in_advance = in_valid_ff && out_free;
   assign req_ready  = !in_valid_ff || out_free;
   assign req_fire   = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= '0;
         hold_ticks_ff     <= HOLD_WIDTH'(3);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_wdata[DEBOUNCE_WIDTH-1:0];
            CSR_HOLD_TICKS:     hold_ticks_ff     <= csr_wdata[HOLD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // input register: hold the request until the result slot frees up
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_fire || (in_valid_ff && !out_free);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff   <= req_cmd;
         in_pins_ff  <= req_pin_levels;
         in_index_ff <= req_key_index;
      end
   end

   always_comb begin
      for (int k = 0; k < KEY_COUNT; k++) begin
         key_ctrl[k].tick      = in_advance && (in_cmd_ff == CMD_TICK);
         key_ctrl[k].pressed   = 1'b0;
         key_ctrl[k].clr_short = in_advance && (in_cmd_ff == CMD_READ_SHORT)
                                 && (in_index_ff == KEY_INDEX_WIDTH'(k));
         key_ctrl[k].clr_long  = in_advance && (in_cmd_ff == CMD_READ_LONG)
                                 && (in_index_ff == KEY_INDEX_WIDTH'(k));
      end
      // keys without a pin read as released
      for (int k = 0; k < KEY_COUNT && k < PIN_BITS; k++) begin
         key_ctrl[k].pressed = !in_pins_ff[k];
      end
   end

   for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
      kslp_key u_key (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (key_ctrl[k]),
         .debounce_ticks (debounce_ticks_ff),
         .hold_ticks     (hold_ticks_ff),
         .flags          (key_flags[k])
      );
   end

   // flag before clearing; an index past the last key reads 0
   always_comb begin
      flag_in = 1'b0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (in_index_ff == KEY_INDEX_WIDTH'(k)) begin
            unique case (in_cmd_ff)
               CMD_READ_SHORT: flag_in = key_flags[k].short_seen;
               CMD_READ_LONG:  flag_in = key_flags[k].long_seen;
               default:        flag_in = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_advance || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         flag_ff <= flag_in;
      end
   end

   // key flags only change when a response is loaded, so they track it
   always_comb begin
      rsp_pending_short = '0;
      rsp_pending_long  = '0;
      for (int k = 0; k < KEY_COUNT && k < PIN_BITS; k++) begin
         rsp_pending_short[k] = key_flags[k].short_seen;
         rsp_pending_long[k]  = key_flags[k].long_seen;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_flag_value = flag_ff;

endmodule

>>> dv/tb_key_short_long_press_detector.sv
// ----------------------------------------------------------------------------
// tb_key_short_long_press_detector
// Drives scan ticks and flag queries into the key press detector. An internal
// model of every key's debounce and hold machine predicts each response, and
// the responses are checked in order while both handshakes stall at random, except in the steady-flow test.
// ----------------------------------------------------------------------------
module tb_key_short_long_press_detector;
   import kslp_pkg::*;

   localparam int      KEY_COUNT    = 5;
   localparam int      CYCLE_LIMIT  = 100000;
   localparam int      DRAIN_CYCLES = 4;
   localparam int      IDLE_PCT     = 34;
   localparam int      REPORT_LIMIT = 10;
   localparam cmd_type CMD_UNUSED   = cmd_type'(2'd3);

   typedef enum logic [1:0] {
      KEY_REST,
      KEY_DEBOUNCE,
      KEY_HOLD,
      KEY_RELEASE_WAIT
   } key_phase_type;

   typedef struct packed {
      logic                flag_value;
      logic [PIN_BITS-1:0] pending_short;
      logic [PIN_BITS-1:0] pending_long;
   } press_report_type;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   cmd_type                    req_cmd        = CMD_TICK;
   logic [PIN_BITS-1:0]        req_pin_levels = '1;
   logic [KEY_INDEX_WIDTH-1:0] req_key_index  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic                       rsp_flag_value;
   logic [PIN_BITS-1:0]        rsp_pending_short;
   logic [PIN_BITS-1:0]        rsp_pending_long;
   logic                       csr_wr_en      = 1'b0;
   csr_index_type              csr_index      = CSR_DEBOUNCE_TICKS;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata      = '0;

   // key model state, starting from the reset values
   logic [DEBOUNCE_WIDTH-1:0] debounce_reload = '0;
   logic [HOLD_WIDTH-1:0]     hold_reload     = 16'd3;
   key_phase_type             key_phase [KEY_COUNT] = '{default: KEY_REST};
   logic [HOLD_WIDTH-1:0]     key_ticks [KEY_COUNT] = '{default: '0};
   logic [KEY_COUNT-1:0]      short_flags = '0;
   logic [KEY_COUNT-1:0]      long_flags  = '0;
   press_report_type          expected_reports [$];

   logic [PIN_BITS-1:0] keys_down     = '0;
   logic                steady_flow   = 1'b0;
   int                  mismatch_count = 0;
   int                  cycle_count    = 0;

   key_short_long_press_detector #(
      .KEY_COUNT(KEY_COUNT)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_pin_levels    (req_pin_levels),
      .req_key_index     (req_key_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_flag_value    (rsp_flag_value),
      .rsp_pending_short (rsp_pending_short),
      .rsp_pending_long  (rsp_pending_long),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic press_report_type predict_press_report(
         cmd_type cmd, logic [PIN_BITS-1:0] pins, logic [KEY_INDEX_WIDTH-1:0] idx);
      press_report_type rep;
      logic             pressed;
      rep = '0;
      case (cmd)
         CMD_TICK: begin
            for (int k = 0; k < KEY_COUNT; k++) begin
               // keys beyond the pin bits always read as released
               pressed = (k < PIN_BITS) ? !pins[k] : 1'b0;
               case (key_phase[k])
                  KEY_REST: begin
                     if (pressed) begin
                        key_ticks[k] = debounce_reload;
                        key_phase[k] = KEY_DEBOUNCE;
                     end
                  end
                  KEY_DEBOUNCE: begin
                     if (key_ticks[k] != 0) begin
                        key_ticks[k]--;
                     end else if (pressed) begin
                        key_ticks[k] = hold_reload;
                        key_phase[k] = KEY_HOLD;
                     end else begin
                        key_phase[k] = KEY_REST;
                     end
                  end
                  KEY_HOLD: begin
                     if (!pressed) begin
                        key_phase[k] = KEY_RELEASE_WAIT;
                     end else if (key_ticks[k] != 0) begin
                        key_ticks[k]--;
                     end else begin
                        long_flags[k] = 1'b1;
                        key_phase[k]  = KEY_REST;
                     end
                  end
                  default: begin
                     if (!pressed) begin
                        short_flags[k] = 1'b1;
                        key_phase[k]   = KEY_REST;
                     end
                  end
               endcase
            end
         end
         CMD_READ_SHORT: begin
            if (idx < KEY_COUNT) begin
               rep.flag_value   = short_flags[idx];
               short_flags[idx] = 1'b0;
            end
         end
         CMD_READ_LONG: begin
            if (idx < KEY_COUNT) begin
               rep.flag_value  = long_flags[idx];
               long_flags[idx] = 1'b0;
            end
         end
         default: ;
      endcase
      rep.pending_short = short_flags[PIN_BITS-1:0];
      rep.pending_long  = long_flags[PIN_BITS-1:0];
      return rep;
   endfunction

   // response checker and ready driver
   always @(posedge clock) begin
      press_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected response: flag %0b short %05b long %05b",
                        rsp_flag_value, rsp_pending_short, rsp_pending_long);
         end else begin
            want = expected_reports.pop_front();
            if (want.flag_value !== rsp_flag_value ||
                want.pending_short !== rsp_pending_short ||
                want.pending_long !== rsp_pending_long) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"response mismatch: expected flag %0b short %05b long %05b,",
                            " got flag %0b short %05b long %05b"},
                           want.flag_value, want.pending_short, want.pending_long,
                           rsp_flag_value, rsp_pending_short, rsp_pending_long);
            end
         end
      end
      rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic send_request(cmd_type cmd, logic [PIN_BITS-1:0] pins,
                               logic [KEY_INDEX_WIDTH-1:0] idx);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_pin_levels <= pins;
      req_key_index  <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_reports.push_back(predict_press_report(cmd, pins, idx));
   endtask

   task automatic wait_for_reports();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_timing(logic [DEBOUNCE_WIDTH-1:0] debounce,
                             logic [HOLD_WIDTH-1:0] hold);
      wait_for_reports();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DEBOUNCE_TICKS;
      // upper byte is junk: the register keeps only its low bits
      csr_wdata <= {8'($urandom_range(255)), debounce};
      @(posedge clock);
      debounce_reload = debounce;
      csr_index <= CSR_HOLD_TICKS;
      csr_wdata <= hold;
      @(posedge clock);
      hold_reload = hold;
      csr_wr_en <= 1'b0;
   endtask

   // press and release keys over many ticks, mixed with flag queries
   task automatic run_key_traffic(int unsigned count, int unsigned toggle_pct,
                                  int unsigned tick_pct);
      logic [PIN_BITS-1:0]        pins;
      logic [KEY_INDEX_WIDTH-1:0] idx;
      int unsigned                roll;
      for (int unsigned n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if ($urandom_range(99) < 85)
            idx = KEY_INDEX_WIDTH'($urandom_range(KEY_COUNT - 1));
         else
            idx = KEY_INDEX_WIDTH'($urandom);
         if (roll < tick_pct) begin
            for (int k = 0; k < PIN_BITS; k++)
               if ($urandom_range(99) < toggle_pct) keys_down[k] = !keys_down[k];
            pins = ~keys_down;
            // contact bounce
            if ($urandom_range(99) < 5) pins = PIN_BITS'($urandom);
            send_request(CMD_TICK, pins, KEY_INDEX_WIDTH'($urandom));
         end else if (roll < 98) begin
            send_request($urandom_range(1) ? CMD_READ_LONG : CMD_READ_SHORT,
                         PIN_BITS'($urandom), idx);
         end else begin
            send_request(CMD_UNUSED, PIN_BITS'($urandom), idx);
         end
      end
   endtask

   task automatic test_directed_presses();
      send_request(CMD_READ_SHORT, 5'b11111, 3'd0);
      send_request(CMD_READ_LONG, 5'b00000, 3'd7);
      send_request(CMD_UNUSED, 5'b00000, 3'd2);
      // short press on key 0, flag read twice
      repeat (2) send_request(CMD_TICK, 5'b11110, 3'd0);
      repeat (2) send_request(CMD_TICK, 5'b11111, 3'd0);
      repeat (2) send_request(CMD_READ_SHORT, 5'b00000, 3'd0);
      // hold every key until the hold count runs out
      repeat (6) send_request(CMD_TICK, 5'b00000, 3'd7);
      send_request(CMD_TICK, 5'b11111, 3'd5);
      send_request(CMD_READ_LONG, 5'b10101, 3'd4);
      send_request(CMD_READ_LONG, 5'b01010, 3'd6);
      send_request(CMD_READ_LONG, 5'b11111, 3'd0);
      // release while still debouncing: no flag
      send_request(CMD_TICK, 5'b10111, 3'd3);
      send_request(CMD_TICK, 5'b11111, 3'd3);
      send_request(CMD_READ_SHORT, 5'b00000, 3'd5);
      send_request(CMD_UNUSED, 5'b11111, 3'd7);
   endtask

   task automatic test_quick_timing();
      set_timing(8'd0, 16'd0);
      run_key_traffic(240, 30, 70);
   endtask

   task automatic test_steady_flow();
      set_timing(8'd2, 16'd5);
      steady_flow = 1'b1;
      run_key_traffic(280, 12, 70);
      steady_flow = 1'b0;
   endtask

   task automatic test_slow_debounce();
      set_timing(8'd255, 16'd0);
      keys_down = '1;
      run_key_traffic(300, 1, 95);
   endtask

   task automatic test_long_hold_window();
      set_timing(8'd1, 16'hFFFF);
      run_key_traffic(180, 25, 70);
   endtask

   task automatic test_pause_then_burst();
      set_timing(8'd0, 16'd3);
      run_key_traffic(100, 15, 70);
      wait_for_reports();
      run_key_traffic(100, 15, 70);
   endtask

   task automatic test_random_timing();
      set_timing(8'($urandom_range(4)), 16'($urandom_range(10)));
      run_key_traffic(200, 18, 70);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_presses();
      test_quick_timing();
      test_steady_flow();
      test_slow_debounce();
      test_long_hold_window();
      test_pause_then_burst();
      test_random_timing();
      wait_for_reports();
      if (mismatch_count == 0 && expected_reports.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
